// ----- design/low_power_listen_rx_controller_defines.svh -----
// Assertion macros used by the low-power-listen receive controller checker.
`ifndef LOW_POWER_LISTEN_RX_CONTROLLER_DEFINES_SVH
`define LOW_POWER_LISTEN_RX_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LPLRX_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LPLRX_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/lplrx_pkg.sv -----
// Types and constants for the low-power-listen receive controller.
`default_nettype none
package lplrx_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LPL_ENABLE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ON_TICKS       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_TICKS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE_TICKS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RSSI_THRESHOLD = 3'd4;

    // register reset values
    localparam logic [15:0] ON_TICKS_RST       = 16'd328;
    localparam logic [15:0] OFF_TICKS_RST      = 16'd3277;
    localparam logic [15:0] PREAMBLE_TICKS_RST = 16'd33;
    localparam logic [15:0] RSSI_THRESHOLD_RST = 16'd32768;

    // event codes
    localparam logic [3:0] ACT_TICK     = 4'd0;
    localparam logic [3:0] ACT_RSSI     = 4'd1;
    localparam logic [3:0] ACT_RX_START = 4'd2;
    localparam logic [3:0] ACT_RX_FAIL  = 4'd3;
    localparam logic [3:0] ACT_FRAME_RX = 4'd4;
    localparam logic [3:0] ACT_LISTEN   = 4'd5;
    localparam logic [3:0] ACT_TRANSMIT = 4'd6;
    localparam logic [3:0] ACT_SLEEP    = 4'd7;
    localparam logic [3:0] ACT_START    = 4'd8;
    localparam logic [3:0] ACT_TX_START = 4'd9;
    localparam logic [3:0] ACT_TX_END   = 4'd10;

    // receive states
    localparam logic [1:0] MODE_SENSE = 2'd0;
    localparam logic [1:0] MODE_PRE   = 2'd1;
    localparam logic [1:0] MODE_FRAME = 2'd2;
    localparam logic [1:0] MODE_SLEEP = 2'd3;

    // radio commands
    localparam logic [1:0] CMD_NONE   = 2'd0;
    localparam logic [1:0] CMD_SLEEP  = 2'd1;
    localparam logic [1:0] CMD_LISTEN = 2'd2;
    localparam logic [1:0] CMD_TX     = 2'd3;

    // upper-layer notifications
    localparam logic [1:0] NT_NONE  = 2'd0;
    localparam logic [1:0] NT_START = 2'd1;
    localparam logic [1:0] NT_FAIL  = 2'd2;
    localparam logic [1:0] NT_FRAME = 2'd3;

    typedef struct packed {
        logic [3:0]  action;
        logic [15:0] rssi_value;
        logic [15:0] start_delay;
    } in_word_t;

    typedef struct packed {
        logic [1:0] radio_cmd;
        logic [1:0] notify;
        logic [1:0] rx_state;
        logic       receiving;
        logic       transmitting;
        logic       event_error;
    } out_word_t;

endpackage
`default_nettype wire

// ----- design/low_power_listen_rx_controller.sv -----
// Low-power-listen receive controller: event-driven state update and duty-cycle timer.
//
//  channel   | ports                       | word
//  ----------+-----------------------------+------------------------------------
//  input     | s_valid s_ready s_data      | event code, RSSI, start delay
//  result    | m_valid m_ready m_data      | radio cmd, notify, state, flags
//  config    | cfg_we cfg_index cfg_data   | register write, no read-back
//
// One event word per clock while s_ready is high; the full state update is combinational logic
// on the state registers, and its result word is registered in the result register or the skid.
// A two-entry output buffer (result register plus skid) keeps s_ready high
// while one finished word waits on m_ready; s_ready drops only when both are full.
// aresetn is synchronous and active low; it clears state and flags and reloads
// the config defaults.
`default_nettype none
module low_power_listen_rx_controller
    import lplrx_pkg::*;
#(
    parameter int TIMER_BITS = 18
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire in_word_t              s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output out_word_t                  m_data,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // wide enough for off + on + preamble and for a full timer value
    localparam int SUM_W = (TIMER_BITS > 18) ? TIMER_BITS : 18;

    logic                  lpl_enable_reg;
    logic [15:0]           on_ticks_reg;
    logic [15:0]           off_ticks_reg;
    logic [15:0]           preamble_ticks_reg;
    logic [15:0]           rssi_threshold_reg;

    logic [1:0]            mode_reg, mode_next;
    logic [TIMER_BITS-1:0] count_reg, count_next;
    logic                  armed_reg, armed_next;
    logic                  fsleep_reg, fsleep_next;
    logic [15:0]           rssi_reg, rssi_next;
    logic                  busy_reg, busy_next;

    out_word_t             out_reg, skid_reg, result;
    logic                  out_valid_reg, skid_valid_reg;

    logic                  in_fire, out_fire;
    logic                  do_expire, do_listen;
    logic [1:0]            cmd, ntf;
    logic                  err;

    function automatic logic [TIMER_BITS-1:0] arm_val(input logic [SUM_W-1:0] t);
        logic [SUM_W-1:0] lim;
        lim = SUM_W'({TIMER_BITS{1'b1}});
        if (t == '0) begin
            return TIMER_BITS'(1);
        end else if (t > lim) begin
            return lim[TIMER_BITS-1:0];
        end else begin
            return t[TIMER_BITS-1:0];
        end
    endfunction

    assign s_ready  = !skid_valid_reg;
    assign in_fire  = s_valid && s_ready;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;
    assign out_fire = out_valid_reg && m_ready;

    always_comb begin
        mode_next   = mode_reg;
        count_next  = count_reg;
        armed_next  = armed_reg;
        fsleep_next = fsleep_reg;
        rssi_next   = rssi_reg;
        busy_next   = busy_reg;
        cmd         = CMD_NONE;
        ntf         = NT_NONE;
        err         = 1'b0;
        do_expire   = 1'b0;
        do_listen   = 1'b0;

        case (s_data.action)
            ACT_TICK: begin
                if (lpl_enable_reg && armed_reg) begin
                    count_next = count_reg - 1'b1;
                    if (count_next == '0) begin
                        armed_next = 1'b0;
                        do_expire  = 1'b1;
                    end
                end
            end
            ACT_RSSI: begin
                rssi_next = s_data.rssi_value;
                if (lpl_enable_reg && s_data.rssi_value < rssi_threshold_reg &&
                    mode_reg == MODE_PRE) begin
                    armed_next = 1'b0;
                    count_next = '0;
                    do_expire  = 1'b1;
                end
            end
            ACT_RX_START: begin
                if (mode_reg inside {MODE_PRE, MODE_SENSE}) begin
                    mode_next = MODE_FRAME;
                    if (lpl_enable_reg) begin
                        armed_next = 1'b0;
                        count_next = '0;
                    end
                    ntf = NT_START;
                end else begin
                    err = 1'b1;
                end
            end
            ACT_RX_FAIL: begin
                if (lpl_enable_reg) begin
                    if (mode_reg == MODE_FRAME) begin
                        mode_next   = MODE_SLEEP;
                        cmd         = CMD_SLEEP;
                        count_next  = arm_val(SUM_W'(off_ticks_reg));
                        armed_next  = 1'b1;
                        fsleep_next = 1'b1;
                    end
                end else begin
                    mode_next = MODE_SENSE;
                end
                ntf = NT_FAIL;
            end
            ACT_FRAME_RX: begin
                if (mode_reg != MODE_FRAME) begin
                    err = 1'b1;
                end else if (lpl_enable_reg) begin
                    mode_next   = MODE_SLEEP;
                    cmd         = CMD_SLEEP;
                    count_next  = arm_val(SUM_W'(2));
                    armed_next  = 1'b1;
                    fsleep_next = 1'b1;
                    ntf         = NT_FRAME;
                end else begin
                    mode_next = MODE_SENSE;
                    ntf       = NT_FRAME;
                end
            end
            ACT_LISTEN: begin
                do_listen = 1'b1;
            end
            ACT_TRANSMIT, ACT_SLEEP: begin
                cmd = (s_data.action == ACT_TRANSMIT) ? CMD_TX : CMD_SLEEP;
                if (lpl_enable_reg) begin
                    armed_next  = 1'b0;
                    count_next  = '0;
                    mode_next   = MODE_SLEEP;
                    fsleep_next = 1'b0;
                end
            end
            ACT_START: begin
                if (lpl_enable_reg) begin
                    count_next = arm_val(SUM_W'(s_data.start_delay));
                    armed_next = 1'b1;
                end
            end
            ACT_TX_START: begin
                if (busy_reg) begin
                    err = 1'b1;
                end else begin
                    busy_next = 1'b1;
                end
            end
            ACT_TX_END: begin
                if (!busy_reg) begin
                    err = 1'b1;
                end else begin
                    busy_next = 1'b0;
                end
            end
            default: begin
                err = 1'b1;
            end
        endcase

        // timer expiry; only reachable with lpl on
        if (do_expire) begin
            fsleep_next = 1'b0;
            case (mode_next)
                MODE_SENSE: begin
                    if (rssi_next < rssi_threshold_reg) begin
                        cmd        = CMD_SLEEP;
                        mode_next  = MODE_SLEEP;
                        count_next = arm_val(SUM_W'(off_ticks_reg));
                    end else begin
                        mode_next  = MODE_PRE;
                        count_next = arm_val(SUM_W'(off_ticks_reg) + SUM_W'(on_ticks_reg) +
                                             SUM_W'(preamble_ticks_reg));
                    end
                    armed_next = 1'b1;
                end
                MODE_PRE: begin
                    ntf        = NT_FAIL;
                    cmd        = CMD_SLEEP;
                    mode_next  = MODE_SLEEP;
                    count_next = arm_val(SUM_W'(off_ticks_reg));
                    armed_next = 1'b1;
                end
                MODE_SLEEP: begin
                    do_listen = 1'b1;
                end
                default: begin
                end
            endcase
        end

        if (do_listen) begin
            cmd = CMD_LISTEN;
            if (lpl_enable_reg && mode_next != MODE_FRAME && mode_next != MODE_PRE &&
                !fsleep_next) begin
                count_next = arm_val(SUM_W'(on_ticks_reg));
                armed_next = 1'b1;
                mode_next  = MODE_SENSE;
            end
        end

        result.radio_cmd    = cmd;
        result.notify       = ntf;
        result.rx_state     = mode_next;
        result.receiving    = (mode_next == MODE_FRAME);
        result.transmitting = busy_next;
        result.event_error  = err;
    end

    // configuration, state and buffer control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lpl_enable_reg     <= 1'b0;
            on_ticks_reg       <= ON_TICKS_RST;
            off_ticks_reg      <= OFF_TICKS_RST;
            preamble_ticks_reg <= PREAMBLE_TICKS_RST;
            rssi_threshold_reg <= RSSI_THRESHOLD_RST;
            mode_reg           <= MODE_SENSE;
            count_reg          <= '0;
            armed_reg          <= 1'b0;
            fsleep_reg         <= 1'b0;
            rssi_reg           <= '0;
            busy_reg           <= 1'b0;
            out_valid_reg      <= 1'b0;
            skid_valid_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_LPL_ENABLE:     lpl_enable_reg     <= cfg_data[0];
                    CFG_ON_TICKS:       on_ticks_reg       <= cfg_data;
                    CFG_OFF_TICKS:      off_ticks_reg      <= cfg_data;
                    CFG_PREAMBLE_TICKS: preamble_ticks_reg <= cfg_data;
                    CFG_RSSI_THRESHOLD: rssi_threshold_reg <= cfg_data;
                    default: begin
                    end
                endcase
            end
            if (in_fire) begin
                mode_reg   <= mode_next;
                count_reg  <= count_next;
                armed_reg  <= armed_next;
                fsleep_reg <= fsleep_next;
                rssi_reg   <= rssi_next;
                busy_reg   <= busy_next;
            end
            if (out_fire) begin
                if (skid_valid_reg) begin
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg <= in_fire;
                end
            end else if (in_fire) begin
                if (!out_valid_reg) begin
                    out_valid_reg <= 1'b1;
                end else begin
                    skid_valid_reg <= 1'b1;
                end
            end
        end
    end

    // result words
    always_ff @(posedge aclk) begin
        if (out_fire) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (in_fire) begin
                out_reg <= result;
            end
        end else if (in_fire) begin
            if (!out_valid_reg) begin
                out_reg <= result;
            end else begin
                skid_reg <= result;
            end
        end
    end

endmodule
`default_nettype wire

// ----- design/lplrx_checker.sv -----
// Port-level checker for the low-power-listen receive controller, with its bind.
`default_nettype none
`include "low_power_listen_rx_controller_defines.svh"
module lplrx_checker
    import lplrx_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_ready,
    input wire logic                  m_valid,
    input wire logic                  m_ready,
    input wire out_word_t             m_data
);

    // a stalled result word must hold
    `LPLRX_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result word changed while stalled")

    // with nothing pending the block must take input
    `LPLRX_ASSERT_IMPLY(a_ready_when_empty, aclk, aresetn, !m_valid, s_ready, "input stalled with empty output")

    `LPLRX_ASSERT_IMPLY(a_recv_flag, aclk, aresetn, m_valid, m_data.receiving == (m_data.rx_state == MODE_FRAME), "receiving flag disagrees with state")

    // an ignored event carries no command and no notification
    `LPLRX_ASSERT_IMPLY(a_err_quiet, aclk, aresetn, m_valid && m_data.event_error, m_data.radio_cmd == CMD_NONE && m_data.notify == NT_NONE, "error word carries a command")

    // a delivered frame always leaves the frame state
    `LPLRX_ASSERT_IMPLY(a_frame_leaves, aclk, aresetn, m_valid && m_data.notify == NT_FRAME, m_data.rx_state != MODE_FRAME, "still in frame after frame received")

endmodule

bind low_power_listen_rx_controller lplrx_checker u_lplrx_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_data    (m_data)
);
`default_nettype wire

// ----- bench/low_power_listen_rx_controller_tb.sv -----
// Self-checking bench for the low-power-listen receive controller.
module low_power_listen_rx_controller_tb;
    import lplrx_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // default timer width of the block
    localparam int TIMER_W = 18;
    localparam int unsigned TIMER_MAX = (1 << TIMER_W) - 1;
    localparam logic [3:0] ACT_UNKNOWN = 4'd15;
    localparam int HALF_PERIOD = 10;
    localparam int RESET_CYCLES = 6;
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES = 200;
    localparam int N_PHASES = 8;
    localparam int WORDS_PER_PHASE = 240;
    localparam int LIMIT_CYCLES = 1_000_000;

    typedef struct packed {
        in_word_t  word;
        logic      typed;
        out_word_t result;
    } script_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_word_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_word_t             m_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    low_power_listen_rx_controller #(
        .TIMER_BITS(TIMER_W)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // register copies
    bit          lpl_on;
    logic [15:0] on_t, off_t, pre_t, thr;

    // controller state copies
    logic [1:0]         mode;
    logic [TIMER_W-1:0] tcount;
    bit                 armed, sleep_forced, tx_busy;
    logic [15:0]        rssi_last;
    logic [1:0]         cmd, ntf;

    out_word_t result_due[$];
    bit        mismatch_seen;
    bit        no_gaps;
    bit        hold_go;

    initial begin
        aclk = 1'b0;
        forever #(HALF_PERIOD) aclk = ~aclk;
    end

    initial begin
        repeat (LIMIT_CYCLES) @(posedge aclk);
        $display("** low_power_listen_rx_controller: FAILED **");
        $finish;
    end

    // ---------------- duty-cycle predictor ----------------

    function automatic void load_timer(longint unsigned ticks);
        if (!lpl_on) return;
        if (ticks == 0) ticks = 1;
        if (ticks > TIMER_MAX) ticks = TIMER_MAX;
        tcount = ticks[TIMER_W-1:0];
        armed = 1'b1;
    endfunction

    function automatic void clear_timer();
        if (!lpl_on) return;
        armed = 1'b0;
        tcount = '0;
    endfunction

    function automatic void enter_listen();
        cmd = CMD_LISTEN;
        if (lpl_on && mode != MODE_FRAME && mode != MODE_PRE && !sleep_forced) begin
            clear_timer();
            load_timer(64'(on_t));
            mode = MODE_SENSE;
        end
    endfunction

    function automatic void on_timeout();
        sleep_forced = 1'b0;
        case (mode)
            MODE_SENSE: begin
                if (rssi_last < thr) begin
                    cmd = CMD_SLEEP;
                    mode = MODE_SLEEP;
                    load_timer(64'(off_t));
                end else begin
                    mode = MODE_PRE;
                    load_timer(64'(off_t) + 64'(on_t) + 64'(pre_t));
                end
            end
            MODE_PRE: begin
                ntf = NT_FAIL;
                cmd = CMD_SLEEP;
                mode = MODE_SLEEP;
                load_timer(64'(off_t));
            end
            MODE_SLEEP: enter_listen();
            default: ;
        endcase
    endfunction

    function automatic out_word_t radio_step(in_word_t w);
        bit        err;
        out_word_t r;
        err = 1'b0;
        cmd = CMD_NONE;
        ntf = NT_NONE;
        case (w.action)
            ACT_TICK: begin
                if (lpl_on && armed) begin
                    tcount = tcount - 1'b1;
                    if (tcount == 0) begin
                        armed = 1'b0;
                        on_timeout();
                    end
                end
            end
            ACT_RSSI: begin
                rssi_last = w.rssi_value;
                if (lpl_on && w.rssi_value < thr && mode == MODE_PRE) begin
                    clear_timer();
                    on_timeout();
                end
            end
            ACT_RX_START: begin
                if (mode == MODE_PRE || mode == MODE_SENSE) begin
                    mode = MODE_FRAME;
                    clear_timer();
                    ntf = NT_START;
                end else begin
                    err = 1'b1;
                end
            end
            ACT_RX_FAIL: begin
                if (lpl_on) begin
                    if (mode == MODE_FRAME) begin
                        mode = MODE_SLEEP;
                        cmd = CMD_SLEEP;
                        load_timer(64'(off_t));
                        sleep_forced = 1'b1;
                    end
                end else begin
                    mode = MODE_SENSE;
                end
                ntf = NT_FAIL;
            end
            ACT_FRAME_RX: begin
                if (mode != MODE_FRAME) begin
                    err = 1'b1;
                end else if (lpl_on) begin
                    mode = MODE_SLEEP;
                    cmd = CMD_SLEEP;
                    load_timer(64'd2);
                    sleep_forced = 1'b1;
                    ntf = NT_FRAME;
                end else begin
                    mode = MODE_SENSE;
                    ntf = NT_FRAME;
                end
            end
            ACT_LISTEN: enter_listen();
            ACT_TRANSMIT, ACT_SLEEP: begin
                cmd = (w.action == ACT_TRANSMIT) ? CMD_TX : CMD_SLEEP;
                if (lpl_on) begin
                    clear_timer();
                    mode = MODE_SLEEP;
                    sleep_forced = 1'b0;
                end
            end
            ACT_START: load_timer(64'(w.start_delay));
            ACT_TX_START: begin
                if (tx_busy) err = 1'b1;
                else tx_busy = 1'b1;
            end
            ACT_TX_END: begin
                if (!tx_busy) err = 1'b1;
                else tx_busy = 1'b0;
            end
            default: err = 1'b1;
        endcase
        r.radio_cmd    = cmd;
        r.notify       = ntf;
        r.rx_state     = mode;
        r.receiving    = (mode == MODE_FRAME);
        r.transmitting = tx_busy;
        r.event_error  = err;
        return r;
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic in_word_t ev(logic [3:0] a, logic [15:0] rv, logic [15:0] sd);
        in_word_t w;
        w.action      = a;
        w.rssi_value  = rv;
        w.start_delay = sd;
        return w;
    endfunction

    function automatic out_word_t outw(logic [1:0] c, logic [1:0] n, logic [1:0] st,
                                       logic rcv, logic tx, logic err);
        out_word_t r;
        r.radio_cmd    = c;
        r.notify       = n;
        r.rx_state     = st;
        r.receiving    = rcv;
        r.transmitting = tx;
        r.event_error  = err;
        return r;
    endfunction

    function automatic script_row_t row(logic [3:0] a, logic [15:0] rv, logic [15:0] sd,
                                        logic typed = 1'b0, out_word_t res = '0);
        script_row_t s;
        s.word   = ev(a, rv, sd);
        s.typed  = typed;
        s.result = res;
        return s;
    endfunction

    function automatic in_word_t random_event();
        in_word_t w;
        int       pick;
        w.rssi_value  = 16'($urandom);
        w.start_delay = 16'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 38) begin
            w.action = ACT_TICK;
        end else if (pick < 52) begin
            w.action = ACT_RSSI;
            // half the updates land right around the threshold
            if ($urandom_range(0, 1) == 0) w.rssi_value = thr + 16'($urandom_range(0, 2)) - 1'b1;
        end else if (pick < 60) begin
            w.action = ACT_RX_START;
        end else if (pick < 65) begin
            w.action = ACT_RX_FAIL;
        end else if (pick < 71) begin
            w.action = ACT_FRAME_RX;
        end else if (pick < 76) begin
            w.action = ACT_LISTEN;
        end else if (pick < 79) begin
            w.action = ACT_TRANSMIT;
        end else if (pick < 82) begin
            w.action = ACT_SLEEP;
        end else if (pick < 88) begin
            w.action = ACT_START;
            if ($urandom_range(0, 9) != 0) w.start_delay = 16'($urandom_range(0, 12));
        end else if (pick < 93) begin
            w.action = ACT_TX_START;
        end else if (pick < 98) begin
            w.action = ACT_TX_END;
        end else begin
            w.action = 4'($urandom_range(ACT_TX_END + 1, ACT_UNKNOWN));
        end
        return w;
    endfunction

    task automatic send_word(in_word_t w, logic typed = 1'b0, out_word_t given = '0);
        out_word_t r;
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        r = radio_step(w);
        result_due = {result_due, (typed ? given : r)};
        if (!no_gaps && $urandom_range(0, 99) < 10) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    task automatic settle_results();
        s_valid <= 1'b0;
        while (result_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // only called with the block idle, so the copies may change at once
    task automatic program_regs(bit en, logic [15:0] on_v, logic [15:0] off_v,
                                logic [15:0] pre_v, logic [15:0] thr_v);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_LPL_ENABLE;
        cfg_data  <= CFG_DATA_W'(en);
        lpl_on = en;
        @(posedge aclk);
        cfg_index <= CFG_ON_TICKS;
        cfg_data  <= on_v;
        on_t = on_v;
        @(posedge aclk);
        cfg_index <= CFG_OFF_TICKS;
        cfg_data  <= off_v;
        off_t = off_v;
        @(posedge aclk);
        cfg_index <= CFG_PREAMBLE_TICKS;
        cfg_data  <= pre_v;
        pre_t = pre_v;
        @(posedge aclk);
        cfg_index <= CFG_RSSI_THRESHOLD;
        cfg_data  <= thr_v;
        thr = thr_v;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // ---------------- result side ----------------

    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_go) begin
                hold_go = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_ready <= no_gaps || ($urandom_range(0, 99) >= 10);
            end
        end
    end

    always @(posedge aclk) begin : result_check
        out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (result_due.size() == 0) begin
                $display("%0t ns: result word with none expected, got %h", $time, m_data);
                mismatch_seen = 1'b1;
            end else begin
                want = result_due.pop_front();
                if (m_data !== want) begin
                    $display("%0t ns: result mismatch, expected %h, got %h",
                             $time, want, m_data);
                    mismatch_seen = 1'b1;
                end
            end
        end
    end

    // ---------------- main sequence ----------------

    initial begin
        script_row_t script[$];
        int          lpl_on_at;

        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_LPL_ENABLE;
        cfg_data  <= '0;
        mismatch_seen = 1'b0;
        no_gaps = 1'b0;
        hold_go = 1'b0;

        lpl_on = 1'b0;
        on_t   = ON_TICKS_RST;
        off_t  = OFF_TICKS_RST;
        pre_t  = PREAMBLE_TICKS_RST;
        thr    = RSSI_THRESHOLD_RST;
        mode   = MODE_SENSE;
        tcount = '0;
        armed  = 1'b0;
        sleep_forced = 1'b0;
        tx_busy   = 1'b0;
        rssi_last = '0;

        // straight after reset, duty cycle off
        script = {script, row(ACT_TICK, 16'h0000, 16'h0001, 1'b1,
                              outw(CMD_NONE, NT_NONE, MODE_SENSE, 1'b0, 1'b0, 1'b0))};
        script = {script, row(ACT_RSSI, 16'hFFFF, 16'h0000, 1'b1,
                              outw(CMD_NONE, NT_NONE, MODE_SENSE, 1'b0, 1'b0, 1'b0))};
        script = {script, row(ACT_START, 16'h0000, 16'hFFFF, 1'b1,
                              outw(CMD_NONE, NT_NONE, MODE_SENSE, 1'b0, 1'b0, 1'b0))};
        script = {script, row(ACT_TX_END, 16'h0000, 16'h0000, 1'b1,
                              outw(CMD_NONE, NT_NONE, MODE_SENSE, 1'b0, 1'b0, 1'b1))};
        script = {script, row(ACT_TX_START, 16'h0000, 16'h0000, 1'b1,
                              outw(CMD_NONE, NT_NONE, MODE_SENSE, 1'b0, 1'b1, 1'b0))};
        script = {script, row(ACT_TX_START, 16'hFFFF, 16'hFFFF, 1'b1,
                              outw(CMD_NONE, NT_NONE, MODE_SENSE, 1'b0, 1'b1, 1'b1))};
        script = {script, row(ACT_UNKNOWN, 16'hFFFF, 16'hFFFF, 1'b1,
                              outw(CMD_NONE, NT_NONE, MODE_SENSE, 1'b0, 1'b1, 1'b1))};
        script = {script, row(ACT_FRAME_RX, 16'h0000, 16'h0000, 1'b1,
                              outw(CMD_NONE, NT_NONE, MODE_SENSE, 1'b0, 1'b1, 1'b1))};
        script = {script, row(ACT_RX_START, 16'h0000, 16'h0000, 1'b1,
                              outw(CMD_NONE, NT_START, MODE_FRAME, 1'b1, 1'b1, 1'b0))};
        script = {script, row(ACT_FRAME_RX, 16'h0000, 16'h0000, 1'b1,
                              outw(CMD_NONE, NT_FRAME, MODE_SENSE, 1'b0, 1'b1, 1'b0))};
        script = {script, row(ACT_RX_FAIL, 16'h0000, 16'h0000, 1'b1,
                              outw(CMD_NONE, NT_FAIL, MODE_SENSE, 1'b0, 1'b1, 1'b0))};
        script = {script, row(ACT_TRANSMIT, 16'h0000, 16'h0000, 1'b1,
                              outw(CMD_TX, NT_NONE, MODE_SENSE, 1'b0, 1'b1, 1'b0))};
        script = {script, row(ACT_TX_END, 16'h0000, 16'h0000)};
        lpl_on_at = script.size();
        // duty cycle on, shortest windows; a zero start delay counts as one tick
        script = {script, row(ACT_START, 16'h0000, 16'h0000)};
        script = {script, row(ACT_TICK, 16'h0000, 16'h0000)};
        script = {script, row(ACT_RSSI, 16'h0000, 16'h0000)};
        script = {script, row(ACT_TICK, 16'h0000, 16'h0000)};
        script = {script, row(ACT_TICK, 16'h0000, 16'h0000)};
        script = {script, row(ACT_LISTEN, 16'h0000, 16'h0000)};
        script = {script, row(ACT_RX_START, 16'h0000, 16'h0000)};
        // timeout while receiving a frame only disarms
        script = {script, row(ACT_START, 16'h0000, 16'h0001)};
        script = {script, row(ACT_TICK, 16'h0000, 16'h0000)};
        script = {script, row(ACT_RX_FAIL, 16'h0000, 16'h0000)};
        script = {script, row(ACT_LISTEN, 16'h0000, 16'h0000)};
        script = {script, row(ACT_RX_START, 16'h0000, 16'h0000, 1'b1,
                              outw(CMD_NONE, NT_NONE, MODE_SLEEP, 1'b0, 1'b0, 1'b1))};
        script = {script, row(ACT_SLEEP, 16'h0000, 16'h0000)};

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < script.size(); i++) begin
            if (i == lpl_on_at) begin
                settle_results();
                program_regs(1'b1, 16'd1, 16'd1, 16'd0, RSSI_THRESHOLD_RST);
            end
            send_word(script[i].word, script[i].typed, script[i].result);
        end

        for (int p = 0; p < N_PHASES; p++) begin
            settle_results();
            case (p)
                0: program_regs(1'b1, 16'd1, 16'd1, 16'd0, RSSI_THRESHOLD_RST);
                1: program_regs(1'b1, 16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)),
                                16'($urandom_range(0, 4)), 16'($urandom));
                2: program_regs(1'b1, 16'd2, 16'd3, 16'd1, 16'h0000);
                3: program_regs(1'b1, 16'd4, 16'd2, 16'd0, 16'hFFFF);
                4: program_regs(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'($urandom));
                5: begin
                    // a whole phase back to back on both sides
                    program_regs(1'b1, 16'd3, 16'd2, 16'd1, 16'($urandom));
                    no_gaps = 1'b1;
                end
                6: program_regs(1'b1, 16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)),
                                16'($urandom_range(0, 8)), 16'($urandom));
                default: program_regs(1'b1, 16'd1, 16'hFFFF, 16'hFFFF, 16'($urandom));
            endcase
            for (int k = 0; k < WORDS_PER_PHASE; k++) begin
                // receiver backs off for a while, sender keeps pushing
                if (p == 6 && k == 60) hold_go = 1'b1;
                send_word(random_event());
            end
            no_gaps = 1'b0;
        end

        settle_results();
        if (!mismatch_seen) begin
            $display("** low_power_listen_rx_controller: PASSED **");
        end else begin
            $display("** low_power_listen_rx_controller: FAILED **");
        end
        $finish;
    end

endmodule

// ----- low_power_listen_rx_controller.f -----
+incdir+design
design/lplrx_pkg.sv
design/low_power_listen_rx_controller.sv
design/lplrx_checker.sv
bench/low_power_listen_rx_controller_tb.sv
